// ===== hw/rtl/zlhne_pkg.sv =====
// ----------------------------------------------------------------------------
// zlhne_pkg
// Types and constants for the ZIP local header name extractor.
// ----------------------------------------------------------------------------
package zlhne_pkg;

  localparam logic [31:0] SigLocal       = 32'h0403_4b50;
  localparam logic [31:0] FlagDescriptor = 32'h0000_0008;

  // Byte counts of the fixed-size header fields
  localparam logic [3:0] LenSig   = 4'd4;
  localparam logic [3:0] LenShort = 4'd2;
  localparam logic [3:0] LenSkip  = 4'd10;
  localparam logic [3:0] LenWord  = 4'd4;

  typedef enum logic [3:0] {
    PH_SIG      = 4'd0,
    PH_VERSION  = 4'd1,
    PH_FLAGS    = 4'd2,
    PH_SKIP10   = 4'd3,
    PH_CSIZE    = 4'd4,
    PH_USIZE    = 4'd5,
    PH_NAMELEN  = 4'd6,
    PH_EXTRALEN = 4'd7,
    PH_NAME     = 4'd8,
    PH_EXTRA    = 4'd9,
    PH_DATA     = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NAME_BYTE  = 2'd0,
    KIND_EMPTY_NAME = 2'd1,
    KIND_END        = 2'd2,
    KIND_DESC_ERROR = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] archive_byte;
    logic       start_of_archive;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] name_byte;
    logic       last_of_name;
  } result_t;

endpackage

// ===== hw/rtl/zlhne_in_stage.sv =====
// ----------------------------------------------------------------------------
// zlhne_in_stage
// Input register: holds one archive byte until the parser takes it.
// ----------------------------------------------------------------------------
module zlhne_in_stage
  import zlhne_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  input  logic  fire_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  // Stall only while a held byte cannot move on this cycle
  assign in_stall_o = valid_q && !fire_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hw/rtl/zlhne_parser.sv =====
// ----------------------------------------------------------------------------
// zlhne_parser
// Header walker: phase register, field accumulator and skip counters.
// ----------------------------------------------------------------------------
module zlhne_parser
  import zlhne_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output logic    res_valid_o,
  output result_t res_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  count_q, count_d;
  logic        done_q, done_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] packed_q, packed_d;
  logic [15:0] name_q, name_d;
  logic [15:0] extra_q, extra_d;

  phase_e      phase_c;
  logic [3:0]  count_c;
  logic        done_c;
  logic [31:0] field;
  logic [7:0]  b;
  logic [15:0] name_dec;
  logic [15:0] extra_dec;
  logic [31:0] packed_dec;

  // A start mark restarts the walk on this very byte
  assign phase_c = item_i.start_of_archive ? PH_SIG : phase_q;
  assign count_c = item_i.start_of_archive ? 4'd0   : count_q;
  assign done_c  = item_i.start_of_archive ? 1'b0   : done_q;
  assign b       = item_i.archive_byte;

  assign field      = ((count_c == 4'd0) ? 32'd0 : shift_q)
                    | (32'(b) << {count_c[1:0], 3'b000});
  assign name_dec   = name_q - 16'd1;
  assign extra_dec  = extra_q - 16'd1;
  assign packed_dec = packed_q - 32'd1;

  always_comb begin
    phase_d     = phase_c;
    count_d     = count_c;
    done_d      = done_c;
    shift_d     = shift_q;
    packed_d    = packed_q;
    name_d      = name_q;
    extra_d     = extra_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_NAME_BYTE, name_byte: 8'd0, last_of_name: 1'b0};

    if (!done_c) begin
      case (phase_c)
        PH_SIG, PH_VERSION, PH_FLAGS, PH_SKIP10, PH_CSIZE, PH_USIZE,
        PH_NAMELEN, PH_EXTRALEN: begin
          shift_d = field;
          count_d = count_c + 4'd1;
        end
        default: ;
      endcase

      case (phase_c)
        PH_SIG: begin
          if (count_c == LenSig - 4'd1) begin
            count_d = 4'd0;
            if (field == SigLocal) begin
              phase_d = PH_VERSION;
            end else begin
              done_d      = 1'b1;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_END;
            end
          end
        end
        PH_VERSION: begin
          if (count_c == LenShort - 4'd1) begin
            count_d = 4'd0;
            phase_d = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          if (count_c == LenShort - 4'd1) begin
            count_d = 4'd0;
            if ((field & FlagDescriptor) != 32'd0) begin
              done_d      = 1'b1;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_DESC_ERROR;
            end else begin
              phase_d = PH_SKIP10;
            end
          end
        end
        PH_SKIP10: begin
          if (count_c == LenSkip - 4'd1) begin
            count_d = 4'd0;
            phase_d = PH_CSIZE;
          end
        end
        PH_CSIZE: begin
          if (count_c == LenWord - 4'd1) begin
            count_d  = 4'd0;
            packed_d = field;
            phase_d  = PH_USIZE;
          end
        end
        PH_USIZE: begin
          if (count_c == LenWord - 4'd1) begin
            count_d = 4'd0;
            phase_d = PH_NAMELEN;
          end
        end
        PH_NAMELEN: begin
          if (count_c == LenShort - 4'd1) begin
            count_d = 4'd0;
            name_d  = field[15:0];
            phase_d = PH_EXTRALEN;
          end
        end
        PH_EXTRALEN: begin
          if (count_c == LenShort - 4'd1) begin
            count_d = 4'd0;
            extra_d = field[15:0];
            if (name_q == 16'd0) begin
              res_valid_o        = 1'b1;
              res_o.kind         = KIND_EMPTY_NAME;
              res_o.last_of_name = 1'b1;
              if (field[15:0] != 16'd0) begin
                phase_d = PH_EXTRA;
              end else if (packed_q != 32'd0) begin
                phase_d = PH_DATA;
              end else begin
                phase_d = PH_SIG;
              end
            end else begin
              phase_d = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          name_d             = name_dec;
          res_valid_o        = 1'b1;
          res_o.name_byte    = b;
          res_o.last_of_name = (name_dec == 16'd0);
          if (name_dec == 16'd0) begin
            if (extra_q != 16'd0) begin
              phase_d = PH_EXTRA;
            end else if (packed_q != 32'd0) begin
              phase_d = PH_DATA;
            end else begin
              phase_d = PH_SIG;
            end
          end
        end
        PH_EXTRA: begin
          extra_d = extra_dec;
          if (extra_dec == 16'd0) begin
            phase_d = (packed_q != 32'd0) ? PH_DATA : PH_SIG;
          end
        end
        PH_DATA: begin
          packed_d = packed_dec;
          if (packed_dec == 32'd0) begin
            phase_d = PH_SIG;
          end
        end
        default: begin
          phase_d = PH_SIG;
          count_d = 4'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SIG;
      count_q  <= 4'd0;
      done_q   <= 1'b0;
      shift_q  <= 32'd0;
      packed_q <= 32'd0;
      name_q   <= 16'd0;
      extra_q  <= 16'd0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      done_q   <= done_d;
      shift_q  <= shift_d;
      packed_q <= packed_d;
      name_q   <= name_d;
      extra_q  <= extra_d;
    end
  end

endmodule

// ===== hw/rtl/zlhne_out_stage.sv =====
// ----------------------------------------------------------------------------
// zlhne_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module zlhne_out_stage
  import zlhne_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  // Free when empty or when the held result transfers this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= fire_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && fire_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/zip_local_header_name_extractor.sv =====
// ----------------------------------------------------------------------------
// zip_local_header_name_extractor
// Walks ZIP local file headers one byte per transfer and reports name bytes.
// ----------------------------------------------------------------------------
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+-----------------------------------
//   in      | in_valid_i  | in_stall_o   | archive_byte_i, start_of_archive_i
//   out     | out_valid_o | out_stall_i  | kind_o, name_byte_o, last_of_name_o
//
// One byte per cycle sustained while no result waits on a stalled output; a
// byte passes the input register, then the result register, before its result
// can transfer out.
// Reset clears the walker to wait for a signature and empties both registers.
// A stall on the output holds the result register; the parser and input
// register stall with it only when a result is still waiting.
module zip_local_header_name_extractor
  import zlhne_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] archive_byte_i,
  input  logic       start_of_archive_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] name_byte_o,
  output logic       last_of_name_o
);

  item_t   item_in;
  item_t   item_q;
  logic    item_valid;
  logic    out_ready;
  logic    fire;
  logic    res_valid;
  result_t res;
  result_t res_q;

  assign item_in = '{archive_byte: archive_byte_i, start_of_archive: start_of_archive_i};
  assign fire    = item_valid && out_ready;

  zlhne_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .fire_i     (fire),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  zlhne_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  zlhne_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign kind_o         = res_q.kind;
  assign name_byte_o    = res_q.name_byte;
  assign last_of_name_o = res_q.last_of_name;

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams ZIP local headers into the name extractor, one byte per transfer.
// A scoreboard walks every accepted byte through its own header parser,
// queues the name, empty-name, end and descriptor-error results it predicts,
// and compares each output transfer field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import zlhne_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned RandomBytes = 1200;
  localparam int unsigned DrainEvery  = 400;
  localparam int unsigned TailCycles  = 16;

  class header_walk_board;
    phase_e      phase;
    logic [31:0] field_acc;
    logic [31:0] field_cnt;
    logic [31:0] data_left;
    logic [15:0] name_left;
    logic [15:0] extra_left;
    bit          walk_done;
    result_t     due_results[$];
    int unsigned errors;
    int unsigned n_name_bytes, n_empty, n_end, n_desc;

    function new();
      clear();
      errors       = 0;
      n_name_bytes = 0;
      n_empty      = 0;
      n_end        = 0;
      n_desc       = 0;
    endfunction

    function void clear();
      phase      = PH_SIG;
      field_acc  = '0;
      field_cnt  = '0;
      data_left  = '0;
      name_left  = '0;
      extra_left = '0;
      walk_done  = 1'b0;
    endfunction

    function void post(kind_e k, logic [7:0] nb, logic last);
      result_t r;
      r.kind         = k;
      r.name_byte    = nb;
      r.last_of_name = last;
      due_results    = {due_results, r};
      case (k)
        KIND_NAME_BYTE:  n_name_bytes++;
        KIND_EMPTY_NAME: n_empty++;
        KIND_END:        n_end++;
        default:         n_desc++;
      endcase
    endfunction

    // Shift one byte into a little endian field; 1 when the field is complete.
    function bit take_field(logic [7:0] b, logic [3:0] len);
      if (field_cnt == 0) field_acc = '0;
      field_acc = field_acc | ({24'b0, b} << {field_cnt[1:0], 3'b000});
      field_cnt++;
      if (field_cnt >= {28'b0, len}) begin
        field_cnt = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void next_after_name();
      if (extra_left != 0) phase = PH_EXTRA;
      else if (data_left != 0) phase = PH_DATA;
      else phase = PH_SIG;
    endfunction

    function void walk_byte(logic [7:0] b, logic start);
      if (start) clear();
      if (walk_done) return;
      case (phase)
        PH_SIG: begin
          if (take_field(b, LenSig)) begin
            if (field_acc == SigLocal) begin
              phase = PH_VERSION;
            end else begin
              walk_done = 1'b1;
              post(KIND_END, 8'h00, 1'b0);
            end
          end
        end
        PH_VERSION: if (take_field(b, LenShort)) phase = PH_FLAGS;
        PH_FLAGS: begin
          if (take_field(b, LenShort)) begin
            if ((field_acc & FlagDescriptor) != 0) begin
              walk_done = 1'b1;
              post(KIND_DESC_ERROR, 8'h00, 1'b0);
            end else begin
              phase = PH_SKIP10;
            end
          end
        end
        PH_SKIP10: if (take_field(b, LenSkip)) phase = PH_CSIZE;
        PH_CSIZE: begin
          if (take_field(b, LenWord)) begin
            data_left = field_acc;
            phase     = PH_USIZE;
          end
        end
        PH_USIZE: if (take_field(b, LenWord)) phase = PH_NAMELEN;
        PH_NAMELEN: begin
          if (take_field(b, LenShort)) begin
            name_left = field_acc[15:0];
            phase     = PH_EXTRALEN;
          end
        end
        PH_EXTRALEN: begin
          if (take_field(b, LenShort)) begin
            extra_left = field_acc[15:0];
            if (name_left == 0) begin
              next_after_name();
              post(KIND_EMPTY_NAME, 8'h00, 1'b1);
            end else begin
              phase = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          name_left--;
          post(KIND_NAME_BYTE, b, name_left == 0);
          if (name_left == 0) next_after_name();
        end
        PH_EXTRA: begin
          extra_left--;
          if (extra_left == 0) phase = (data_left != 0) ? PH_DATA : PH_SIG;
        end
        PH_DATA: begin
          data_left--;
          if (data_left == 0) phase = PH_SIG;
        end
        default: begin
          phase     = PH_SIG;
          field_cnt = '0;
        end
      endcase
    endfunction

    function void match_result(logic [1:0] k, logic [7:0] nb, logic last);
      result_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing expected: kind %0d name_byte %02h last %0b",
               k, nb, last);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (k !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, k);
        errors++;
      end
      if (nb !== want.name_byte) begin
        $error("name_byte: expected %02h, got %02h", want.name_byte, nb);
        errors++;
      end
      if (last !== want.last_of_name) begin
        $error("last_of_name: expected %0b, got %0b", want.last_of_name, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i              = 1'b0;
  logic       rst_ni             = 1'b0;
  logic       in_valid_i         = 1'b0;
  logic       in_stall_o;
  logic [7:0] archive_byte_i     = 8'h00;
  logic       start_of_archive_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i        = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] name_byte_o;
  logic       last_of_name_o;

  header_walk_board board = new();
  bit          mark_next   = 1'b0;
  bit          quiet_ports = 1'b0;
  int unsigned sent_bytes  = 0;
  int unsigned cycle_cnt   = 0;

  zip_local_header_name_extractor u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .archive_byte_i     (archive_byte_i),
    .start_of_archive_i (start_of_archive_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .name_byte_o        (name_byte_o),
    .last_of_name_o     (last_of_name_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    return quiet_ports ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic start);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    archive_byte_i     <= b;
    start_of_archive_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    board.walk_byte(b, start);
    sent_bytes++;
  endtask

  task automatic emit(input logic [7:0] b);
    send_item(b, mark_next);
    mark_next = 1'b0;
  endtask

  task automatic emit_le(input logic [31:0] v, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) emit(8'(v >> (8 * i)));
  endtask

  task automatic emit_header(input logic [15:0] flags, input logic [31:0] csize,
                             input logic [15:0] nlen, input logic [15:0] elen);
    emit_le(SigLocal, 4);
    emit_le($urandom, 2);
    emit_le({16'b0, flags}, 2);
    // the walk ends on the flags, so stop here
    if ((flags & FlagDescriptor[15:0]) != 0) return;
    repeat (10) emit(8'($urandom));
    emit_le(csize, 4);
    emit_le($urandom, 4);
    emit_le({16'b0, nlen}, 2);
    emit_le({16'b0, elen}, 2);
    repeat (nlen) emit(8'($urandom));
    repeat (elen) emit(8'($urandom));
    repeat (csize) emit(8'($urandom));
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.due_results.size() != 0);
  endtask

  task automatic random_archive();
    int unsigned n_hdr, r;
    logic [31:0] cs;
    logic [15:0] nl, el, fl;
    n_hdr       = $urandom_range(1, 4);
    mark_next   = 1'b1;
    quiet_ports = ($urandom_range(0, 3) == 0);
    repeat (n_hdr) begin
      r  = $urandom_range(0, 15);
      cs = (r < 5) ? 32'd0 : (r == 15) ? $urandom_range(200, 300) : $urandom_range(1, 8);
      r  = $urandom_range(0, 63);
      nl = (r < 16) ? 16'd0
                    : 16'((r == 63) ? $urandom_range(256, 270) : $urandom_range(1, 10));
      r  = $urandom_range(0, 63);
      el = (r < 24) ? 16'd0
                    : 16'((r == 63) ? $urandom_range(256, 260) : $urandom_range(1, 4));
      fl = 16'($urandom) & ~FlagDescriptor[15:0];
      emit_header(fl, cs, nl, el);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // broken signature, then bytes that the ended walk ignores
        repeat (4) emit(8'($urandom));
        repeat ($urandom_range(0, 3)) emit(8'($urandom));
      end
      4, 5: emit_header(16'($urandom) | FlagDescriptor[15:0], 32'd0, 16'd0, 16'd0);
      6, 7: begin
        // cut the header short; the next start mark restarts the walk
        emit_le(SigLocal, 4);
        repeat ($urandom_range(0, 20)) emit(8'($urandom));
      end
      default: repeat ($urandom_range(1, 8)) emit(8'($urandom));
    endcase
  endtask

  // Result side: stall for a drawn number of cycles, then take one transfer.
  initial begin
    int unsigned n;
    wait (rst_ni);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      board.match_result(kind_o, name_byte_o, last_of_name_o);
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned next_drain;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // no start mark after reset: parse from the first byte, bad signature
    mark_next = 1'b0;
    emit(8'h00); emit(8'hFF); emit(8'h00); emit(8'hFF);
    // walk has ended: ignore these
    emit(8'h50); emit(8'h4B);
    // restart, all-ones flags carry the data-descriptor bit
    mark_next = 1'b1;
    emit_header(16'hFFFF, 32'd0, 16'd0, 16'd0);
    // restart in the middle of a signature, then a bad one
    mark_next = 1'b1;
    emit(8'h50); emit(8'h4B); emit(8'h03);
    mark_next = 1'b1;
    repeat (4) emit(8'hFF);
    hold_until_drained();

    next_drain = sent_bytes + DrainEvery;
    while (sent_bytes < RandomBytes) begin
      random_archive();
      if (sent_bytes >= next_drain) begin
        hold_until_drained();
        next_drain = sent_bytes + DrainEvery;
      end
    end

    in_valid_i <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("sent %0d archive bytes in %0d cycles", sent_bytes, cycle_cnt);
    $display("checked %0d name bytes, %0d empty names, %0d ends, %0d descriptor errors",
             board.n_name_bytes, board.n_empty, board.n_end, board.n_desc);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== zip_local_header_name_extractor.f =====
hw/rtl/zlhne_pkg.sv
hw/rtl/zlhne_in_stage.sv
hw/rtl/zlhne_parser.sv
hw/rtl/zlhne_out_stage.sv
hw/rtl/zip_local_header_name_extractor.sv
tb/sv/testbench.sv
